### src/rmf_pkg.sv
`default_nettype none

package rmf_pkg;

   // Field and register widths.
   localparam int unsigned CH_W    = 8;
   localparam int unsigned FW_W    = 11;
   localparam int unsigned FH_W    = 13;
   localparam int unsigned CSR_W   = 13;
   localparam int unsigned CSR_A_W = 1;

   // Input row counter runs a few rows past the frame while it drains.
   localparam int unsigned ROW_W  = 13;
   localparam int unsigned OROW_W = 12;

   localparam int unsigned HEIGHT_LIMIT = 4096;
   localparam int unsigned WIDTH_RESET  = 640;
   localparam int unsigned HEIGHT_RESET = 480;

   localparam int unsigned WIN_ROWS = 3;
   localparam int unsigned WIN_COLS = 3;
   localparam int unsigned WIN_TAPS = WIN_ROWS * WIN_COLS;

   localparam int unsigned MID_DEPTH = 4;
   localparam int unsigned OUT_DEPTH = 4;

   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

   // Register indexes of the configuration port.
   localparam logic [CSR_A_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   // Per-item control decided by the front end.
   typedef struct packed {
      logic emit;
      logic last;
      logic top_skip;
      logic bot_skip;
      logic left_skip;
      logic right_skip;
   } ctl_type;

   typedef struct packed {
      pixel_type peak;
      logic      frame_end;
   } result_type;

   function automatic pixel_type pix_max(input pixel_type a, input pixel_type b);
      pixel_type m;
      m.red   = (a.red   > b.red)   ? a.red   : b.red;
      m.green = (a.green > b.green) ? a.green : b.green;
      m.blue  = (a.blue  > b.blue)  ? a.blue  : b.blue;
      return m;
   endfunction

   // Last row index of the frame in use: zero acts as one row, too many rows clamp.
   function automatic logic [OROW_W-1:0] height_last(input logic [FH_W-1:0] raw);
      if (raw == '0) begin
         return '0;
      end else if (raw > FH_W'(HEIGHT_LIMIT)) begin
         return OROW_W'(HEIGHT_LIMIT - 1);
      end else begin
         return OROW_W'(raw - 1'b1);
      end
   endfunction

endpackage

`default_nettype wire

### src/rmf_queue.sv
`default_nettype none

// Small register FIFO. DEPTH is a power of two, two or more.
module rmf_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             wdata,
   input  logic                         pop,
   output logic [WIDTH-1:0]             rdata,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

### src/rmf_front.sv
`default_nettype none

// Front end: frame geometry, input and output position counters, and the
// per-item decision of what the window pipeline has to do.
module rmf_front #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [rmf_pkg::CSR_A_W-1:0]        csr_index,
   input  logic [rmf_pkg::CSR_W-1:0]          csr_data,
   input  logic                               in_accept,
   input  logic                               in_func,
   input  rmf_pkg::pixel_type                 in_pix,
   output logic                               q_push,
   output rmf_pkg::ctl_type                   q_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0]       q_col,
   output rmf_pkg::pixel_type                 q_pix
);

   localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W  = rmf_pkg::ROW_W;
   localparam int unsigned OROW_W = rmf_pkg::OROW_W;

   function automatic logic [COL_W-1:0] width_last(input logic [rmf_pkg::FW_W-1:0] raw);
      logic [31:0] wide;
      wide = 32'(raw);
      if (wide == 32'd0) begin
         return '0;
      end else if (wide > 32'(MAX_WIDTH)) begin
         return COL_W'(MAX_WIDTH - 1);
      end else begin
         return COL_W'(wide - 32'd1);
      end
   endfunction

   logic [COL_W-1:0]  w_last_ff, w_last_in;
   logic [OROW_W-1:0] h_last_ff, h_last_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;

   logic done_in, take, col_wrap, emit, last;

   // All pixels of the frame are in once the row counter passes the last row.
   assign done_in  = (in_row_ff > ROW_W'(h_last_ff));
   // A drain before the frame is complete is dropped.
   assign take     = in_accept && !(in_func && !done_in);
   assign col_wrap = (in_col_ff == w_last_ff);
   assign emit     = (in_row_ff >= ROW_W'(2)) ||
                     ((in_row_ff == ROW_W'(1)) && !col_wrap && (in_col_ff != '0));
   assign last     = (out_row_ff == h_last_ff) && (out_col_ff == w_last_ff);

   assign q_push           = take;
   assign q_col            = in_col_ff;
   assign q_pix            = done_in ? '0 : in_pix;
   assign q_ctl.emit       = emit;
   assign q_ctl.last       = emit && last;
   assign q_ctl.top_skip   = (out_row_ff == '0);
   assign q_ctl.bot_skip   = (out_row_ff == h_last_ff);
   assign q_ctl.left_skip  = (out_col_ff == '0);
   assign q_ctl.right_skip = (out_col_ff == w_last_ff);

   always_comb begin
      w_last_in  = w_last_ff;
      h_last_in  = h_last_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rmf_pkg::CSR_FRAME_WIDTH: begin
               w_last_in = width_last(csr_data[rmf_pkg::FW_W-1:0]);
            end
            rmf_pkg::CSR_FRAME_HEIGHT: begin
               h_last_in = rmf_pkg::height_last(csr_data[rmf_pkg::FH_W-1:0]);
            end
            default: begin
               w_last_in = w_last_ff;
            end
         endcase
         // Any register write abandons a partial frame.
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_ff == w_last_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff  <= width_last(rmf_pkg::FW_W'(rmf_pkg::WIDTH_RESET));
         h_last_ff  <= rmf_pkg::height_last(rmf_pkg::FH_W'(rmf_pkg::HEIGHT_RESET));
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         w_last_ff  <= w_last_in;
         h_last_ff  <= h_last_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

`default_nettype wire

### src/rmf_back.sv
`default_nettype none

// Back end: row stores, 3x3 window and the masked maximum. Items issue only
// when the result queue has room for everything in flight, so the pipeline
// itself never stalls.
module rmf_back #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          q_empty,
   output logic                                          q_pop,
   input  rmf_pkg::ctl_type                              q_ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0]                  q_col,
   input  rmf_pkg::pixel_type                            q_pix,
   input  logic [$clog2(rmf_pkg::OUT_DEPTH+1)-1:0]       out_count,
   output logic                                          out_push,
   output rmf_pkg::result_type                           out_data
);

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned NC    = rmf_pkg::WIN_COLS;
   localparam int unsigned NR    = rmf_pkg::WIN_ROWS;

   rmf_pkg::pixel_type older_mem [MAX_WIDTH];
   rmf_pkg::pixel_type newer_mem [MAX_WIDTH];

   rmf_pkg::pixel_type rd_older_ff, rd_newer_ff;
   rmf_pkg::pixel_type prev_mid_ff;
   rmf_pkg::pixel_type win_ff [rmf_pkg::WIN_TAPS];

   logic               p1_v_ff, p2_v_ff;
   logic               p1_fwd_ff;
   logic [COL_W-1:0]   p1_col_ff;
   rmf_pkg::pixel_type p1_pix_ff;
   rmf_pkg::ctl_type   p1_ctl_ff, p2_ctl_ff;

   logic               issue;
   rmf_pkg::pixel_type top, mid;
   rmf_pkg::pixel_type sel [rmf_pkg::WIN_TAPS];
   rmf_pkg::pixel_type row_peak [NR];
   rmf_pkg::pixel_type best;

   assign issue = !q_empty &&
                  ((32'(out_count) + 32'(p1_v_ff) + 32'(p2_v_ff)) < 32'(rmf_pkg::OUT_DEPTH));
   assign q_pop = issue;

   // The older store is written in the cycle after its read, so an item that
   // follows at the same column takes the top value from its predecessor.
   assign mid = rd_newer_ff;
   assign top = p1_fwd_ff ? prev_mid_ff : rd_older_ff;

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_newer_ff      <= newer_mem[q_col];
         newer_mem[q_col] <= q_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_older_ff <= older_mem[q_col];
      end
      if (p1_v_ff) begin
         older_mem[p1_col_ff] <= mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= issue;
         p2_v_ff <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p1_col_ff <= q_col;
         p1_pix_ff <= q_pix;
         p1_ctl_ff <= q_ctl;
         p1_fwd_ff <= p1_v_ff && (p1_col_ff == q_col);
      end
      if (p1_v_ff) begin
         prev_mid_ff <= mid;
         p2_ctl_ff   <= p1_ctl_ff;
         for (int r = 0; r < NR; r++) begin
            win_ff[r*NC]     <= win_ff[r*NC + 1];
            win_ff[r*NC + 1] <= win_ff[r*NC + 2];
         end
         win_ff[NC - 1]     <= top;
         win_ff[2*NC - 1]   <= mid;
         win_ff[3*NC - 1]   <= p1_pix_ff;
      end
   end

   // Taps outside the frame count as zero.
   always_comb begin
      for (int r = 0; r < NR; r++) begin
         for (int c = 0; c < NC; c++) begin
            if (((r == 0) && p2_ctl_ff.top_skip) || ((r == NR - 1) && p2_ctl_ff.bot_skip) ||
                ((c == 0) && p2_ctl_ff.left_skip) ||
                ((c == NC - 1) && p2_ctl_ff.right_skip)) begin
               sel[r*NC + c] = '0;
            end else begin
               sel[r*NC + c] = win_ff[r*NC + c];
            end
         end
      end
      for (int r = 0; r < NR; r++) begin
         row_peak[r] = rmf_pkg::pix_max(rmf_pkg::pix_max(sel[r*NC], sel[r*NC + 1]),
                                        sel[r*NC + 2]);
      end
      best = rmf_pkg::pix_max(rmf_pkg::pix_max(row_peak[0], row_peak[1]), row_peak[2]);
   end

   assign out_push           = p2_v_ff && p2_ctl_ff.emit;
   assign out_data.peak      = best;
   assign out_data.frame_end = p2_ctl_ff.last;

endmodule

`default_nettype wire

### src/rgb_max_filter_3x3.sv
`default_nettype none

// 3x3 per-channel maximum filter (dilation of R, G and B) over a raster pixel
// stream. Each transfer on the request side carries one pixel (req_func = 0)
// or a drain step (req_func = 1); while results are popped, the block sustains
// one transfer per clock, limited by its row stores, which take one read and
// one write per item. The result for a pixel appears one row plus about one
// pixel of input later, so after the last pixel of a frame the user sends
// drain steps until the result with rsp_frame_end set has come out; drains
// sent before the frame is complete are dropped, and pixels sent after it act
// as drains. Pixels outside the frame count as zero and rsp_alpha_out is always
// 255. A result passes through the command queue, the window pipeline and the
// result queue before it is visible on the response ports. Writing
// either geometry register restarts the frame and must be done while the
// block is idle; width 0 acts as 1 and widths beyond MAX_WIDTH clamp to it,
// height 0 acts as 1 and heights beyond 4096 clamp to 4096. The row stores
// are not cleared after reset since rows from before the current frame are
// always masked out, so the block is ready right after reset.
module rgb_max_filter_3x3 #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_func,
   input  logic [rmf_pkg::CH_W-1:0]     req_red,
   input  logic [rmf_pkg::CH_W-1:0]     req_green,
   input  logic [rmf_pkg::CH_W-1:0]     req_blue,

   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [rmf_pkg::CH_W-1:0]     rsp_red_max,
   output logic [rmf_pkg::CH_W-1:0]     rsp_green_max,
   output logic [rmf_pkg::CH_W-1:0]     rsp_blue_max,
   output logic [rmf_pkg::CH_W-1:0]     rsp_alpha_out,
   output logic                         rsp_frame_end,

   input  logic                         csr_wr_en,
   input  logic [rmf_pkg::CSR_A_W-1:0]  csr_index,
   input  logic [rmf_pkg::CSR_W-1:0]    csr_data
);

   localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
   localparam int unsigned PIX_W   = $bits(rmf_pkg::pixel_type);
   localparam int unsigned CTL_W   = $bits(rmf_pkg::ctl_type);
   localparam int unsigned MID_W   = CTL_W + COL_W + PIX_W;
   localparam int unsigned RES_W   = $bits(rmf_pkg::result_type);
   localparam int unsigned OCNT_W  = $clog2(rmf_pkg::OUT_DEPTH + 1);

   rmf_pkg::pixel_type  in_pix;
   logic                in_accept;

   // Front end to command queue.
   logic                f_push;
   rmf_pkg::ctl_type    f_ctl;
   logic [COL_W-1:0]    f_col;
   rmf_pkg::pixel_type  f_pix;
   logic [MID_W-1:0]    mid_wdata, mid_rdata;
   logic                mid_empty;

   // Command queue to back end.
   logic                b_pop;
   rmf_pkg::ctl_type    b_ctl;
   logic [COL_W-1:0]    b_col;
   rmf_pkg::pixel_type  b_pix;

   // Back end to result queue.
   logic                res_push;
   rmf_pkg::result_type res_wdata, res_rdata;
   logic [RES_W-1:0]    res_rdata_raw;
   logic [OCNT_W-1:0]   res_count;

   assign in_pix.red   = req_red;
   assign in_pix.green = req_green;
   assign in_pix.blue  = req_blue;
   assign in_accept    = req_push && !req_full;

   rmf_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_accept (in_accept),
      .in_func   (req_func),
      .in_pix    (in_pix),
      .q_push    (f_push),
      .q_ctl     (f_ctl),
      .q_col     (f_col),
      .q_pix     (f_pix)
   );

   assign mid_wdata = {f_ctl, f_col, f_pix};

   // The command queue lets the front end keep taking transfers while the
   // back end waits for room in the result queue.
   rmf_queue #(
      .WIDTH (MID_W),
      .DEPTH (rmf_pkg::MID_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (mid_wdata),
      .pop   (b_pop),
      .rdata (mid_rdata),
      .full  (req_full),
      .empty (mid_empty),
      .count ()
   );

   assign b_ctl = rmf_pkg::ctl_type'(mid_rdata[MID_W-1 -: CTL_W]);
   assign b_col = mid_rdata[PIX_W +: COL_W];
   assign b_pix = rmf_pkg::pixel_type'(mid_rdata[PIX_W-1:0]);

   rmf_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (mid_empty),
      .q_pop     (b_pop),
      .q_ctl     (b_ctl),
      .q_col     (b_col),
      .q_pix     (b_pix),
      .out_count (res_count),
      .out_push  (res_push),
      .out_data  (res_wdata)
   );

   // Results wait here, so a stalled consumer never holds up the input side
   // until the queue and the window pipeline are full.
   rmf_queue #(
      .WIDTH (RES_W),
      .DEPTH (rmf_pkg::OUT_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_wdata),
      .pop   (rsp_pop),
      .rdata (res_rdata_raw),
      .full  (),
      .empty (rsp_empty),
      .count (res_count)
   );

   assign res_rdata     = rmf_pkg::result_type'(res_rdata_raw);
   assign rsp_red_max   = res_rdata.peak.red;
   assign rsp_green_max = res_rdata.peak.green;
   assign rsp_blue_max  = res_rdata.peak.blue;
   assign rsp_frame_end = res_rdata.frame_end;
   assign rsp_alpha_out = rmf_pkg::ALPHA_OPAQUE;

endmodule

`default_nettype wire
